### hdl/gzip_header_skipper_defines.svh
// assertion macros used by the gzip header skipper checker
`ifndef GZIP_HEADER_SKIPPER_DEFINES_SVH
`define GZIP_HEADER_SKIPPER_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define GHS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gzip header skipper check failed");

// next-cycle implication, disabled while reset is low
`define GHS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gzip header skipper check failed");

`endif

### hdl/ghs_pkg.sv
// types, codes and flag helpers for the gzip header skipper
package ghs_pkg;

  // header parse phases, one-hot
  typedef enum logic [12:0] {
    PH_MAGIC1  = 13'b0_0000_0000_0001,
    PH_MAGIC2  = 13'b0_0000_0000_0010,
    PH_METHOD  = 13'b0_0000_0000_0100,
    PH_FLAGS   = 13'b0_0000_0000_1000,
    PH_FIXED   = 13'b0_0000_0001_0000,
    PH_XLEN_LO = 13'b0_0000_0010_0000,
    PH_XLEN_HI = 13'b0_0000_0100_0000,
    PH_XDATA   = 13'b0_0000_1000_0000,
    PH_NAME    = 13'b0_0001_0000_0000,
    PH_COMMENT = 13'b0_0010_0000_0000,
    PH_HCRC    = 13'b0_0100_0000_0000,
    PH_PAYLOAD = 13'b0_1000_0000_0000,
    PH_ERROR   = 13'b1_0000_0000_0000
  } phase_e;

  // byte tag codes
  localparam logic [1:0] KIND_HEADER  = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_ERROR   = 2'd2;

  // fixed header bytes
  localparam logic [7:0] MAGIC1_BYTE = 8'd31;
  localparam logic [7:0] MAGIC2_BYTE = 8'd139;
  localparam logic [7:0] METHOD_BYTE = 8'd8;

  // flag bit positions
  localparam int unsigned FLG_HCRC_BIT    = 1;
  localparam int unsigned FLG_EXTRA_BIT   = 2;
  localparam int unsigned FLG_NAME_BIT    = 3;
  localparam int unsigned FLG_COMMENT_BIT = 4;

  // byte counts of the fixed skips
  localparam logic [15:0] FIXED_SKIP = 16'd6;
  localparam logic [15:0] HCRC_SKIP  = 16'd2;

  // first optional field still allowed whose flag is set, else header CRC if flagged, else payload
  function automatic phase_e next_optional(logic allow_extra, logic allow_name,
                                           logic allow_comment, logic [7:0] flags);
    phase_e nxt;
    if (allow_extra && flags[FLG_EXTRA_BIT]) begin
      nxt = PH_XLEN_LO;
    end else if (allow_name && flags[FLG_NAME_BIT]) begin
      nxt = PH_NAME;
    end else if (allow_comment && flags[FLG_COMMENT_BIT]) begin
      nxt = PH_COMMENT;
    end else if (flags[FLG_HCRC_BIT]) begin
      nxt = PH_HCRC;
    end else begin
      nxt = PH_PAYLOAD;
    end
    return nxt;
  endfunction

endpackage

### hdl/gzip_header_skipper.sv
// gzip member header skipper: tags each stream byte as header, payload or error
//
// Usage: compressed bytes enter on the s_axis channel, one byte per request.
// Every accepted byte leaves once on the m_axis channel, unchanged in tdata,
// with a tag in tuser: header byte consumed, payload byte for the deflate
// decoder, or header error. Magic bytes 31, 139 and method 8 are checked,
// the flag byte is kept, six fixed bytes are skipped, then the optional
// extra field, name, comment and header CRC, each only if its flag is set.
// An accepted byte is offered on m_axis in the next cycle. Throughput is
// one byte per cycle: the parse state and the output register update in the
// same cycle, so a new byte is taken whenever the output register is empty
// or being drained. When the receiver stalls, the result holds in the
// output register and s_axis_tready_o drops until it is taken.
// Reset puts the parser back at the first magic byte and empties the
// output register. A header error is sticky until reset; after the header
// every byte is tagged payload until reset.
module gzip_header_skipper (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] in_byte
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] out_byte
  output logic [1:0] m_axis_tuser_o    // [1:0] byte_kind
);

  ghs_pkg::phase_e phase_q, phase_d;
  logic [7:0]  flags_q, flags_d;
  logic [7:0]  xlen_lo_q, xlen_lo_d;
  logic [15:0] skip_q, skip_d;
  logic [15:0] skip_dec;
  logic [15:0] xlen_full;
  logic [1:0]  kind_d;
  logic        out_valid_q;
  logic [7:0]  out_byte_q;
  logic [1:0]  out_kind_q;
  logic        in_fire;

  // handshake: take a byte when the output slot is free or draining
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  assign skip_dec  = skip_q - 16'd1;
  assign xlen_full = {s_axis_tdata_i, xlen_lo_q};

  // next parse state for the incoming byte
  always_comb begin
    phase_d   = phase_q;
    flags_d   = flags_q;
    xlen_lo_d = xlen_lo_q;
    skip_d    = skip_q;
    kind_d    = ghs_pkg::KIND_HEADER;
    unique case (phase_q)
      ghs_pkg::PH_MAGIC1: begin
        if (s_axis_tdata_i == ghs_pkg::MAGIC1_BYTE) begin
          phase_d = ghs_pkg::PH_MAGIC2;
        end else begin
          phase_d = ghs_pkg::PH_ERROR;
          kind_d  = ghs_pkg::KIND_ERROR;
        end
      end
      ghs_pkg::PH_MAGIC2: begin
        if (s_axis_tdata_i == ghs_pkg::MAGIC2_BYTE) begin
          phase_d = ghs_pkg::PH_METHOD;
        end else begin
          phase_d = ghs_pkg::PH_ERROR;
          kind_d  = ghs_pkg::KIND_ERROR;
        end
      end
      ghs_pkg::PH_METHOD: begin
        if (s_axis_tdata_i == ghs_pkg::METHOD_BYTE) begin
          phase_d = ghs_pkg::PH_FLAGS;
        end else begin
          phase_d = ghs_pkg::PH_ERROR;
          kind_d  = ghs_pkg::KIND_ERROR;
        end
      end
      ghs_pkg::PH_FLAGS: begin
        flags_d = s_axis_tdata_i;
        skip_d  = ghs_pkg::FIXED_SKIP;
        phase_d = ghs_pkg::PH_FIXED;
      end
      ghs_pkg::PH_FIXED: begin
        skip_d = skip_dec;
        if (skip_dec == '0) begin
          phase_d = ghs_pkg::next_optional(1'b1, 1'b1, 1'b1, flags_q);
        end
      end
      ghs_pkg::PH_XLEN_LO: begin
        xlen_lo_d = s_axis_tdata_i;
        phase_d   = ghs_pkg::PH_XLEN_HI;
      end
      ghs_pkg::PH_XLEN_HI: begin
        skip_d = xlen_full;
        if (xlen_full == '0) begin
          phase_d = ghs_pkg::next_optional(1'b0, 1'b1, 1'b1, flags_q);
        end else begin
          phase_d = ghs_pkg::PH_XDATA;
        end
      end
      ghs_pkg::PH_XDATA: begin
        skip_d = skip_dec;
        if (skip_dec == '0) begin
          phase_d = ghs_pkg::next_optional(1'b0, 1'b1, 1'b1, flags_q);
        end
      end
      ghs_pkg::PH_NAME: begin
        if (s_axis_tdata_i == '0) begin
          phase_d = ghs_pkg::next_optional(1'b0, 1'b0, 1'b1, flags_q);
        end
      end
      ghs_pkg::PH_COMMENT: begin
        if (s_axis_tdata_i == '0) begin
          phase_d = ghs_pkg::next_optional(1'b0, 1'b0, 1'b0, flags_q);
        end
      end
      ghs_pkg::PH_HCRC: begin
        skip_d = skip_dec;
        if (skip_dec == '0) begin
          phase_d = ghs_pkg::PH_PAYLOAD;
        end
      end
      ghs_pkg::PH_PAYLOAD: begin
        kind_d = ghs_pkg::KIND_PAYLOAD;
      end
      default: begin
        phase_d = ghs_pkg::PH_ERROR;
        kind_d  = ghs_pkg::KIND_ERROR;
      end
    endcase
    // header crc always starts with a two-byte count
    if (phase_d == ghs_pkg::PH_HCRC && phase_q != ghs_pkg::PH_HCRC) begin
      skip_d = ghs_pkg::HCRC_SKIP;
    end
  end

  // parse state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= ghs_pkg::PH_MAGIC1;
      flags_q   <= '0;
      xlen_lo_q <= '0;
      skip_q    <= '0;
    end else if (in_fire) begin
      phase_q   <= phase_d;
      flags_q   <= flags_d;
      xlen_lo_q <= xlen_lo_d;
      skip_q    <= skip_d;
    end
  end

  // output valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // output payload register
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_byte_q <= s_axis_tdata_i;
      out_kind_q <= kind_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_byte_q;
  assign m_axis_tuser_o  = out_kind_q;

endmodule

### hdl/ghs_checker.sv
// port-level checker for the gzip header skipper, bound to the top level
`include "gzip_header_skipper_defines.svh"

module ghs_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid_i,
  input logic       s_axis_tready_o,
  input logic [7:0] s_axis_tdata_i,   // [7:0] in_byte
  input logic       m_axis_tvalid_o,
  input logic       m_axis_tready_i,
  input logic [7:0] m_axis_tdata_o,   // [7:0] out_byte
  input logic [1:0] m_axis_tuser_o    // [1:0] byte_kind
);

  logic out_fire;
  logic seen_err_q;
  logic seen_pay_q;

  assign out_fire = m_axis_tvalid_o && m_axis_tready_i;

  // remember whether an error or payload byte has left
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_err_q <= 1'b0;
      seen_pay_q <= 1'b0;
    end else if (out_fire) begin
      if (m_axis_tuser_o == ghs_pkg::KIND_ERROR) begin
        seen_err_q <= 1'b1;
      end
      if (m_axis_tuser_o == ghs_pkg::KIND_PAYLOAD) begin
        seen_pay_q <= 1'b1;
      end
    end
  end

  // a stalled result holds
  `GHS_ASSERT_NEXT(a_stall_hold, clk_i, rst_ni,
                   m_axis_tvalid_o && !m_axis_tready_i,
                   m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))

  // each accepted byte shows up next cycle unchanged
  `GHS_ASSERT_NEXT(a_pass_through, clk_i, rst_ni,
                   s_axis_tvalid_i && s_axis_tready_o,
                   m_axis_tvalid_o && m_axis_tdata_o == $past(s_axis_tdata_i))

  // once an error leaves, every later byte is an error
  `GHS_ASSERT_NOW(a_error_sticky, clk_i, rst_ni,
                  m_axis_tvalid_o && seen_err_q,
                  m_axis_tuser_o == ghs_pkg::KIND_ERROR)

  // once payload starts, every later byte is payload
  `GHS_ASSERT_NOW(a_payload_sticky, clk_i, rst_ni,
                  m_axis_tvalid_o && seen_pay_q,
                  m_axis_tuser_o == ghs_pkg::KIND_PAYLOAD)

endmodule

bind gzip_header_skipper ghs_checker u_ghs_checker (.*);
